### sv/apt_pkg.sv
// Shared definitions for the accelerated parameter tuner.
// Holds the sequencer state type, opcode and register codes and fixed field widths.
// No dependencies.
package apt_pkg;

    localparam int OP_W   = 3;
    localparam int IDX_W  = 4;
    localparam int TICK_W = 32;
    localparam int OUT_W  = 16;
    localparam int CNT_W  = 8;
    localparam int WIN_W  = 16;
    localparam int CFG_W  = 16;

    // Opcodes of an input request.
    localparam logic [OP_W-1:0] OP_TUNE       = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD_VALUE = 3'd1;
    localparam logic [OP_W-1:0] OP_LOAD_MAX   = 3'd2;
    localparam logic [OP_W-1:0] OP_LOAD_MIN   = 3'd3;
    localparam logic [OP_W-1:0] OP_LOAD_STEP  = 3'd4;
    localparam logic [OP_W-1:0] OP_COMMIT     = 3'd5;
    localparam logic [OP_W-1:0] OP_SYNC       = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_WINDOW    = 1'b1;

    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 8'd2;
    localparam logic [WIN_W-1:0] WINDOW_RESET    = 16'd25;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_FETCH,
        ST_GAP,
        ST_WIN,
        ST_MUL,
        ST_ADD,
        ST_CMAX,
        ST_CMIN,
        ST_WRITE
    } state_t;

endpackage

### sv/apt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the parameter table of the tuner. No dependencies.
module apt_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/accelerated_parameter_tuner.sv
// Top level of the accelerated parameter tuner: sequencer, shared adder and table RAM.
// Depends on apt_pkg and apt_ram.
//
// One request is taken when start is high and busy is low; busy then stays high until the
// result is written back, and the result appears on the output ports for one cycle with done
// high, in the same cycle in which busy has fallen again. Results cannot be held off.
// A tune steps through READ, FETCH, GAP, WIN, MUL, ADD, CMAX, CMIN and WRITE, skipping CMAX
// and CMIN when a decrease would fall below zero; other opcodes step through READ, FETCH and
// WRITE, and an index beyond the table goes straight to WRITE. A new request may start in the
// cycle done is shown. The steps come from the registered table RAM read and from one 32-bit
// adder used in turn for the tick gap, the window compare, the step and both limit compares.
// The configuration port is always ready and should be written only while the block is idle.
module accelerated_parameter_tuner #(
    parameter int NUM_ENTRIES = 16,
    parameter int VALUE_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [apt_pkg::OP_W-1:0]    opcode,
    input  logic [apt_pkg::IDX_W-1:0]   param_index,
    input  logic                        direction,
    input  logic [apt_pkg::TICK_W-1:0]  time_stamp,
    input  logic [apt_pkg::OUT_W-1:0]   data_value,
    output logic                        done,
    output logic [apt_pkg::OUT_W-1:0]   committed_value,
    output logic [apt_pkg::OUT_W-1:0]   pending_value,
    output logic [apt_pkg::OUT_W-1:0]   lower_limit,
    output logic [apt_pkg::OUT_W-1:0]   upper_limit,
    output logic [apt_pkg::OUT_W-1:0]   applied_step,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [apt_pkg::CFG_W-1:0]   cfg_data
);

    import apt_pkg::*;

    localparam int ADDR_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int ROW_W  = 5 * VALUE_BITS;
    localparam int ALU_W  = TICK_W;
    localparam int PROD_W = VALUE_BITS + CNT_W + 1;

    state_t state_reg, state_next;

    // Configuration registers.
    logic [CNT_W-1:0] thr_reg, thr_next;
    logic [WIN_W-1:0] win_reg, win_next;

    // History of the last tune.
    logic [IDX_W-1:0]  prev_idx_reg, prev_idx_next;
    logic              prev_dir_reg, prev_dir_next;
    logic              prev_valid_reg, prev_valid_next;
    logic [TICK_W-1:0] prev_tick_reg, prev_tick_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              done_reg, done_next;

    // Request and working registers.
    logic [OP_W-1:0]       op_reg, op_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic                  dir_reg, dir_next;
    logic [TICK_W-1:0]     now_reg, now_next;
    logic [VALUE_BITS-1:0] data_reg, data_next;
    logic                  inrange_reg, inrange_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [VALUE_BITS-1:0] pend_reg, pend_next;
    logic [VALUE_BITS-1:0] min_reg, min_next;
    logic [VALUE_BITS-1:0] max_reg, max_next;
    logic [VALUE_BITS-1:0] step_reg, step_next;
    logic [VALUE_BITS-1:0] tstep_reg, tstep_next;
    logic [VALUE_BITS-1:0] cand_reg, cand_next;
    logic [TICK_W-1:0]     gap_reg, gap_next;
    logic                  within_reg, within_next;
    logic                  over_reg, over_next;

    logic [OUT_W-1:0] out_val_reg, out_val_next;
    logic [OUT_W-1:0] out_pend_reg, out_pend_next;
    logic [OUT_W-1:0] out_min_reg, out_min_next;
    logic [OUT_W-1:0] out_max_reg, out_max_next;
    logic [OUT_W-1:0] out_step_reg, out_step_next;

    // Shared adder/subtractor. For a subtraction bit ALU_W is set when a >= b.
    logic [ALU_W-1:0] alu_a;
    logic [ALU_W-1:0] alu_b;
    logic             alu_sub;
    logic [ALU_W:0]   alu_res;

    logic                        ram_we;
    logic [ADDR_W-1:0]           ram_addr;
    logic [ROW_W-1:0]            ram_wdata;
    logic [ROW_W-1:0]            ram_rdata;
    logic                        accept;
    logic                        repeat_hit;
    logic [CNT_W:0]              count_inc;
    logic [PROD_W-1:0]           product;

    assign accept    = start && (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign alu_res   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                       + {{ALU_W{1'b0}}, alu_sub};
    assign ram_addr  = ADDR_W'(idx_reg);
    assign ram_wdata = {step_reg, max_reg, min_reg, pend_reg, val_reg};
    assign count_inc = {1'b0, count_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign product   = PROD_W'(tstep_reg) * PROD_W'(count_inc);
    assign repeat_hit = prev_valid_reg && (prev_idx_reg == idx_reg)
                        && (prev_dir_reg == dir_reg) && within_reg;

    apt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_ENTRIES)
    ) u_apt_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_addr),
        .wdata (ram_wdata),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (32'(param_index) < 32'(NUM_ENTRIES)) ? ST_READ : ST_WRITE;
                end
            end
            ST_READ:  state_next = ST_FETCH;
            ST_FETCH: state_next = (op_reg == OP_TUNE) ? ST_GAP : ST_WRITE;
            ST_GAP:   state_next = ST_WIN;
            ST_WIN:   state_next = ST_MUL;
            ST_MUL:   state_next = ST_ADD;
            ST_ADD:
            begin
                state_next = (dir_reg && !alu_res[ALU_W]) ? ST_WRITE : ST_CMAX;
            end
            ST_CMAX:  state_next = ST_CMIN;
            ST_CMIN:  state_next = ST_WRITE;
            ST_WRITE: state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: busy, RAM write and adder operands.
    always_comb
    begin
        busy    = (state_reg != ST_IDLE);
        ram_we  = 1'b0;
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b1;
        unique case (state_reg)
            ST_GAP:
            begin
                alu_a = now_reg;
                alu_b = prev_tick_reg;
            end
            ST_WIN:
            begin
                alu_a = ALU_W'(win_reg);
                alu_b = gap_reg;
            end
            ST_ADD:
            begin
                alu_a   = ALU_W'(pend_reg);
                alu_b   = ALU_W'(tstep_reg);
                alu_sub = dir_reg;
            end
            ST_CMAX:
            begin
                alu_a = ALU_W'(max_reg);
                alu_b = ALU_W'(cand_reg);
            end
            ST_CMIN:
            begin
                alu_a = ALU_W'(cand_reg);
                alu_b = ALU_W'(min_reg);
            end
            ST_WRITE:
            begin
                ram_we = inrange_reg;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Configuration, datapath and history updates.
    always_comb
    begin
        thr_next        = thr_reg;
        win_next        = win_reg;
        prev_idx_next   = prev_idx_reg;
        prev_dir_next   = prev_dir_reg;
        prev_valid_next = prev_valid_reg;
        prev_tick_next  = prev_tick_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        op_next         = op_reg;
        idx_next        = idx_reg;
        dir_next        = dir_reg;
        now_next        = now_reg;
        data_next       = data_reg;
        inrange_next    = inrange_reg;
        val_next        = val_reg;
        pend_next       = pend_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        step_next       = step_reg;
        tstep_next      = tstep_reg;
        cand_next       = cand_reg;
        gap_next        = gap_reg;
        within_next     = within_reg;
        over_next       = over_reg;
        out_val_next    = out_val_reg;
        out_pend_next   = out_pend_reg;
        out_min_next    = out_min_reg;
        out_max_next    = out_max_reg;
        out_step_next   = out_step_reg;

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_THRESHOLD: thr_next = cfg_data[CNT_W-1:0];
                CFG_WINDOW:    win_next = cfg_data[WIN_W-1:0];
                default:       thr_next = thr_reg;
            endcase
        end

        if (accept)
        begin
            op_next      = opcode;
            idx_next     = param_index;
            dir_next     = direction;
            now_next     = time_stamp;
            data_next    = VALUE_BITS'(data_value);
            inrange_next = (32'(param_index) < 32'(NUM_ENTRIES));
        end

        case (state_reg)
            ST_FETCH:
            begin
                val_next   = ram_rdata[0*VALUE_BITS +: VALUE_BITS];
                pend_next  = ram_rdata[1*VALUE_BITS +: VALUE_BITS];
                min_next   = ram_rdata[2*VALUE_BITS +: VALUE_BITS];
                max_next   = ram_rdata[3*VALUE_BITS +: VALUE_BITS];
                step_next  = ram_rdata[4*VALUE_BITS +: VALUE_BITS];
                // The stored step stays as loaded; a tune works on its own copy.
                tstep_next = ram_rdata[4*VALUE_BITS +: VALUE_BITS];
                unique case (op_reg)
                    OP_LOAD_VALUE:
                    begin
                        val_next  = data_reg;
                        pend_next = data_reg;
                    end
                    OP_LOAD_MAX:  max_next  = data_reg;
                    OP_LOAD_MIN:  min_next  = data_reg;
                    OP_LOAD_STEP: step_next = data_reg;
                    OP_COMMIT:    val_next  = ram_rdata[1*VALUE_BITS +: VALUE_BITS];
                    OP_SYNC:      pend_next = ram_rdata[0*VALUE_BITS +: VALUE_BITS];
                    default:      val_next  = ram_rdata[0*VALUE_BITS +: VALUE_BITS];
                endcase
            end
            ST_GAP:
            begin
                gap_next = alu_res[TICK_W-1:0];
            end
            ST_WIN:
            begin
                within_next = alu_res[ALU_W];
            end
            ST_MUL:
            begin
                // The step is scaled by the old count plus one.
                if (repeat_hit)
                begin
                    if (count_reg >= thr_reg)
                    begin
                        tstep_next = product[VALUE_BITS-1:0];
                    end
                    count_next = count_inc[CNT_W-1:0];
                end
                if (!within_reg)
                begin
                    count_next = '0;
                end
                prev_tick_next  = now_reg;
                prev_idx_next   = idx_reg;
                prev_dir_next   = dir_reg;
                prev_valid_next = 1'b1;
            end
            ST_ADD:
            begin
                cand_next = alu_res[VALUE_BITS-1:0];
                // A decrease that would go below zero lands on the minimum directly.
                if (dir_reg && !alu_res[ALU_W])
                begin
                    pend_next = min_reg;
                end
            end
            ST_CMAX:
            begin
                over_next = !alu_res[ALU_W];
            end
            ST_CMIN:
            begin
                if (over_reg)
                begin
                    pend_next = max_reg;
                end
                else if (!alu_res[ALU_W])
                begin
                    pend_next = min_reg;
                end
                else
                begin
                    pend_next = cand_reg;
                end
            end
            ST_WRITE:
            begin
                done_next = 1'b1;
                if (inrange_reg)
                begin
                    out_val_next  = OUT_W'(val_reg);
                    out_pend_next = OUT_W'(pend_reg);
                    out_min_next  = OUT_W'(min_reg);
                    out_max_next  = OUT_W'(max_reg);
                    out_step_next = (op_reg == OP_TUNE) ? OUT_W'(tstep_reg) : '0;
                end
                else
                begin
                    out_val_next  = '0;
                    out_pend_next = '0;
                    out_min_next  = '0;
                    out_max_next  = '0;
                    out_step_next = '0;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            thr_reg        <= THRESHOLD_RESET;
            win_reg        <= WINDOW_RESET;
            prev_idx_reg   <= '0;
            prev_dir_reg   <= 1'b0;
            prev_valid_reg <= 1'b0;
            prev_tick_reg  <= '0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            thr_reg        <= thr_next;
            win_reg        <= win_next;
            prev_idx_reg   <= prev_idx_next;
            prev_dir_reg   <= prev_dir_next;
            prev_valid_reg <= prev_valid_next;
            prev_tick_reg  <= prev_tick_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        idx_reg      <= idx_next;
        dir_reg      <= dir_next;
        now_reg      <= now_next;
        data_reg     <= data_next;
        inrange_reg  <= inrange_next;
        val_reg      <= val_next;
        pend_reg     <= pend_next;
        min_reg      <= min_next;
        max_reg      <= max_next;
        step_reg     <= step_next;
        tstep_reg    <= tstep_next;
        cand_reg     <= cand_next;
        gap_reg      <= gap_next;
        within_reg   <= within_next;
        over_reg     <= over_next;
        out_val_reg  <= out_val_next;
        out_pend_reg <= out_pend_next;
        out_min_reg  <= out_min_next;
        out_max_reg  <= out_max_next;
        out_step_reg <= out_step_next;
    end

    assign done            = done_reg;
    assign committed_value = out_val_reg;
    assign pending_value   = out_pend_reg;
    assign lower_limit     = out_min_reg;
    assign upper_limit     = out_max_reg;
    assign applied_step    = out_step_reg;

endmodule

### sv/apt_checker.sv
// Port-level checks on the request and result timing of the tuner.
// Attached to accelerated_parameter_tuner by the bind statement at the end of this file.
module apt_checker (
    input logic clk,
    input logic rst_n,
    input logic start,
    input logic busy,
    input logic done
);

    // A result is only shown once the request has finished.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result shown while a request is still in progress");

    // Every accepted request occupies the block from the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> (busy && !done))
        else $error("request accepted but block not busy");

    // Results are single-cycle strobes.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe longer than one cycle");

    // Finishing a request always produces a result.
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy) |-> done)
        else $error("request finished without a result");

endmodule

bind accelerated_parameter_tuner apt_checker u_apt_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);
